// ----- rtl/core/passive_ds_velocity_damping_force_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the passive damping force core.
// Concurrent checks are compiled in simulation and drop out in synthesis.
// ----------------------------------------------------------------------------
`ifndef PASSIVE_DS_VELOCITY_DAMPING_FORCE_CORE_DEFINES_SVH
`define PASSIVE_DS_VELOCITY_DAMPING_FORCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PDVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PDVD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PDVD_ASSERT(label, prop, msg)
`define PDVD_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- rtl/core/pdvd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdvd_pkg
// Types and constants shared by the passive damping force core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdvd_pkg;

  // Quotient bits of the projection divider; |p| stays below 2^33.
  localparam int unsigned QuotW    = 33;
  // Pipeline index of the first divider step.
  localparam int unsigned DivFirst = 4;
  // Number of stages that carry side data (through the product stage).
  localparam int unsigned NumStg   = DivFirst + QuotW + 2;

  localparam int unsigned DampW = 24;
  localparam logic [DampW-1:0] DampReset = 24'd6553600;

  typedef enum logic [0:0] {
    REG_ALONG  = 1'b0,
    REG_ACROSS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] measured_vx;
    logic signed [31:0] measured_vy;
    logic signed [31:0] measured_vz;
    logic signed [31:0] desired_vx;
    logic signed [31:0] desired_vy;
    logic signed [31:0] desired_vz;
  } vel_beat_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } force_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/passive_ds_velocity_damping_force_core.sv -----
// Each accepted velocity beat becomes its force beat through the registered product, divider and output stages.
// Throughput: one beat per cycle while the output is not stalled; the 33-step pipelined projection divider
// and the multiplier stages each take a new beat every cycle.
// The whole pipeline holds while a finished force beat is not taken.
// Reset clears all valid bits; both damping registers reset to 100.0.
// ----------------------------------------------------------------------------
// passive_ds_velocity_damping_force_core
// Damping force F = l0*d - l1*v - (l0-l1)*((d.v)/(d.d))*d, or -v for d = 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "passive_ds_velocity_damping_force_core_defines.svh"

module passive_ds_velocity_damping_force_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [0:0]               cfg_idx_i,
  input  wire logic [23:0]              cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire pdvd_pkg::vel_beat_t      in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output pdvd_pkg::force_beat_t         out_data_o
);
  import pdvd_pkg::*;

  typedef struct packed {
    logic               zero;
    logic               dv_neg;
    logic [2:0][31:0]   v;
    logic [2:0][31:0]   d;
    logic [63:0]        dd;
  } meta_t;

  localparam int unsigned StgP   = DivFirst + QuotW;
  localparam int unsigned StgMul = StgP + 1;

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [47:0] x);
    logic [31:0] r;
    if ((x[47:31] == '0) || (x[47:31] == '1)) begin
      r = x[31:0];
    end else if (x[47]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic en;
  logic [NumStg-1:0] vld_q;
  meta_t meta_q [NumStg];

  logic [DampW-1:0] l0_q, l1_q;

  // Damping registers; a zero write is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l0_q <= DampReset;
      l1_q <= DampReset;
    end else if (cfg_we_i && (cfg_data_i != '0)) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ALONG:  l0_q <= cfg_data_i;
        REG_ACROSS: l1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or drained.
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NumStg-2:0], in_valid_i};
      out_valid_q <= vld_q[NumStg-1];
    end
  end

  // Side data shifts along with the beats.
  meta_t meta_in;
  always_comb begin
    meta_in        = '0;
    meta_in.v[0]   = in_data_i.measured_vx;
    meta_in.v[1]   = in_data_i.measured_vy;
    meta_in.v[2]   = in_data_i.measured_vz;
    meta_in.d[0]   = in_data_i.desired_vx;
    meta_in.d[1]   = in_data_i.desired_vy;
    meta_in.d[2]   = in_data_i.desired_vz;
  end

  logic signed [65:0] dv_sum;
  logic [63:0]        dd_sum;
  logic signed [63:0] pr_q [3];
  logic [62:0]        sq_q [3];

  always_comb begin
    dv_sum = '0;
    dd_sum = '0;
    for (int i = 0; i < 3; i++) begin
      dv_sum = dv_sum + {{2{pr_q[i][63]}}, pr_q[i]};
      dd_sum = dd_sum + {1'b0, sq_q[i]};
    end
  end

  // Stage 1 side data picks up the squared norm and the sign of d.v.
  meta_t meta_s1;
  always_comb begin
    meta_s1        = meta_q[0];
    meta_s1.dd     = dd_sum;
    meta_s1.zero   = (dd_sum == '0);
    meta_s1.dv_neg = dv_sum[65];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_in;
      meta_q[1] <= meta_s1;
      for (int s = 2; s < NumStg; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // Stage 0: component products d*v and d*d.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= signed'(meta_in.d[i]) * signed'(meta_in.v[i]);
        sq_q[i] <= 63'(signed'(meta_in.d[i]) * signed'(meta_in.d[i]));
      end
    end
  end

  // Stage 1: magnitude of the dot product.
  logic [65:0] dv_abs;
  logic [63:0] dvm_q;
  assign dv_abs = dv_sum[65] ? 66'(-dv_sum) : 66'(dv_sum);
  always_ff @(posedge clk_i) begin
    if (en) begin
      dvm_q <= dv_abs[63:0];
    end
  end

  // Stage 2: partial products |d.v| * |d_i|, split in 32-bit halves.
  logic [63:0] pl_q [3];
  logic [63:0] ph_q [3];
  logic [31:0] dabs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = meta_q[1].d[i][31] ? 32'(-meta_q[1].d[i]) : meta_q[1].d[i];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= 64'(dvm_q[31:0]) * 64'(dabs[i]);
        ph_q[i] <= 64'(dvm_q[63:32]) * 64'(dabs[i]);
      end
    end
  end

  // Stage 3 loads the divider; each later stage retires one quotient bit.
  logic [2:0][63:0]      rem_q [QuotW+1];
  logic [2:0][QuotW-1:0] low_q [QuotW+1];
  logic [2:0][QuotW-1:0] quo_q [QuotW+1];
  logic [95:0]           num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {32'd0, pl_q[i]} + {ph_q[i], 32'd0};
    end
  end

  logic [2:0][63:0]      rem_d [QuotW+1];
  logic [2:0][QuotW-1:0] low_d [QuotW+1];
  logic [2:0][QuotW-1:0] quo_d [QuotW+1];

  always_comb begin
    logic [64:0] trial;
    logic [64:0] diff;
    trial = '0;
    diff  = '0;
    for (int i = 0; i < 3; i++) begin
      rem_d[0][i] = {1'b0, num[i][95:QuotW]};
      low_d[0][i] = num[i][QuotW-1:0];
      quo_d[0][i] = '0;
    end
    for (int j = 1; j <= QuotW; j++) begin
      for (int i = 0; i < 3; i++) begin
        trial = {rem_q[j-1][i], low_q[j-1][i][QuotW-1]};
        diff  = trial - {1'b0, meta_q[DivFirst+j-2].dd};
        if (!diff[64]) begin
          rem_d[j][i] = diff[63:0];
          quo_d[j][i] = {quo_q[j-1][i][QuotW-2:0], 1'b1};
        end else begin
          rem_d[j][i] = trial[63:0];
          quo_d[j][i] = {quo_q[j-1][i][QuotW-2:0], 1'b0};
        end
        low_d[j][i] = {low_q[j-1][i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j <= QuotW; j++) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  // Signed projection p_i, sign from d.v and d_i.
  logic signed [33:0] p_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (meta_q[StgP-1].dv_neg != meta_q[StgP-1].d[i][31]) begin
          p_q[i] <= -signed'({1'b0, quo_q[QuotW][i]});
        end else begin
          p_q[i] <= signed'({1'b0, quo_q[QuotW][i]});
        end
      end
    end
  end

  // Eigenvalue products.
  logic signed [24:0] l0_s, l1_s, ldiff;
  assign l0_s  = signed'({1'b0, l0_q});
  assign l1_s  = signed'({1'b0, l1_q});
  assign ldiff = l0_s - l1_s;

  logic signed [56:0] t0_q [3];
  logic signed [56:0] t1_q [3];
  logic signed [58:0] t2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t0_q[i] <= 57'(l0_s) * 57'(signed'(meta_q[StgP].d[i]));
        t1_q[i] <= 57'(l1_s) * 57'(signed'(meta_q[StgP].v[i]));
        t2_q[i] <= 59'(ldiff) * 59'(p_q[i]);
      end
    end
  end

  // Final sum, floor shift and saturation into the output register.
  logic signed [60:0] ssum [3];
  logic signed [32:0] vneg [3];
  logic [2:0][31:0]   force_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ssum[i] = 61'(t0_q[i]) - 61'(t1_q[i]) - 61'(t2_q[i]);
      vneg[i] = -33'(signed'(meta_q[StgMul].v[i]));
      if (meta_q[StgMul].zero) begin
        force_d[i] = sat32(48'(vneg[i]));
      end else begin
        force_d[i] = sat32(48'(ssum[i] >>> 16));
      end
    end
  end

  force_beat_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.force_x <= force_d[0];
      out_q.force_y <= force_d[1];
      out_q.force_z <= force_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every final remainder of a live, nonzero-norm beat stays below d.d.
  logic rem_ok;
  assign rem_ok = !vld_q[StgP-1] || meta_q[StgP-1].zero ||
                  ((rem_q[QuotW][0] < meta_q[StgP-1].dd) &&
                   (rem_q[QuotW][1] < meta_q[StgP-1].dd) &&
                   (rem_q[QuotW][2] < meta_q[StgP-1].dd));

  // Checks on the pipeline and the divider.
  `PDVD_ASSERT(a_damp_nonzero, (l0_q != '0) && (l1_q != '0), "damping register is zero")
  `PDVD_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_q), "pipeline moved while stalled")
  `PDVD_ASSERT(a_rem_bound, rem_ok, "divider remainder out of range")

endmodule

`default_nettype wire
